[hw/rtl/frnl_pkg.sv]
`timescale 1ns / 1ps

package frnl_pkg;

  // fixed field widths
  localparam int INDEX_W     = 6;
  localparam int INDEX_SPACE = 64;
  localparam int COORD_W     = 16;
  localparam int CNT_W       = 7;
  localparam int RADIUS_W    = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // defaults for the top-level parameters
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 1'd1;
  localparam logic [CNT_W-1:0]     POINT_COUNT_RST = 7'd64;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST      = 16'd320;

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_BAD
  } cmd_e;

  typedef struct packed {
    cmd_e                kind;
    logic [INDEX_W-1:0]  index;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
  } cmd_t;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_QPOINT,
    TOK_CAND,
    TOK_END
  } tok_e;

  typedef struct packed {
    tok_e               kind;
    logic [INDEX_W-1:0] idx;
    logic               bad;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END
  } state_e;

endpackage

[hw/rtl/frnl_front.sv]
`timescale 1ns / 1ps

module frnl_front #(
  parameter int MAX_POINTS = frnl_pkg::MAX_POINTS_DEF
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [frnl_pkg::INDEX_W-1:0] point_index_i,
  input  logic [frnl_pkg::COORD_W-1:0] coord_x_i,
  input  logic [frnl_pkg::COORD_W-1:0] coord_y_i,
  input  logic [frnl_pkg::CNT_W-1:0]   n_eff_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output frnl_pkg::cmd_t              q_cmd_o
);
  import frnl_pkg::*;

  localparam int Depth = (MAX_POINTS < INDEX_SPACE) ? MAX_POINTS : INDEX_SPACE;

  logic drop;

  always_comb begin
    drop          = 1'b0;
    q_cmd_o.index = point_index_i;
    q_cmd_o.x     = coord_x_i;
    q_cmd_o.y     = coord_y_i;
    if (operation_i == OP_LOAD) begin
      // loads beyond the table are swallowed here
      q_cmd_o.kind = CMD_LOAD;
      drop         = CNT_W'(point_index_i) >= CNT_W'(Depth);
    end else if (CNT_W'(point_index_i) >= n_eff_i) begin
      q_cmd_o.kind = CMD_BAD;
    end else begin
      q_cmd_o.kind = CMD_QUERY;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && !drop;

endmodule

[hw/rtl/frnl_queue.sv]
`timescale 1ns / 1ps

module frnl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  frnl_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output frnl_pkg::cmd_t cmd_o,
  input  logic           pop_i
);
  import frnl_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_pop;

  assign full_o  = count_q == (QPTR_W + 1)'(QDEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hw/rtl/frnl_back.sv]
`timescale 1ns / 1ps

module frnl_back #(
  parameter int MAX_POINTS = frnl_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = frnl_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  frnl_pkg::cmd_t                q_cmd_i,
  output logic                          q_pop_o,
  input  logic [frnl_pkg::CNT_W-1:0]    n_eff_i,
  input  logic [frnl_pkg::RADIUS_W-1:0] radius_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [frnl_pkg::INDEX_W-1:0]  neighbor_index_o,
  output logic                          neighbor_valid_o,
  output logic                          last_o,
  output logic                          bad_index_o
);
  import frnl_pkg::*;

  localparam int Depth = (MAX_POINTS < INDEX_SPACE) ? MAX_POINTS : INDEX_SPACE;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int PW    = 2 * CW;
  localparam int RW    = 2 * RADIUS_W;
  localparam int SW    = RW + 1;

  logic [PW-1:0]  mem [Depth];
  logic [PW-1:0]  rd_q;
  logic           mem_we;
  logic [AW-1:0]  iss_addr;

  state_e         state_q, state_d;
  logic [AW-1:0]  j_q, j_d;
  logic [AW-1:0]  slot_q, slot_d;
  tok_t           iss_tok;
  tok_t           tok1_q, tok2_q, tok3_q;
  logic           adv;
  logic           scan_last;

  logic [CW-1:0]  qx_q, qy_q;
  logic [CW-1:0]  rx, ry;
  logic [CW-1:0]  dx_d, dy_d, dx_q, dy_q;
  logic [PW-1:0]  sx_d, sy_d, sx_q, sy_q;
  logic [RW-1:0]  r2_q;
  logic [SW-1:0]  dist_sum;
  logic           hit;

  logic           pend_v_q;
  logic [INDEX_W-1:0] pend_idx_q;
  logic           out_v_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic           out_nv_q, out_last_q, out_bad_q;

  // the whole scan pipe moves only when the output register can take a word
  assign adv       = !out_v_q || !out_stall_i;
  assign scan_last = (CNT_W'(j_q) + CNT_W'(1)) == n_eff_i;

  always_comb begin
    state_d      = state_q;
    j_d          = j_q;
    slot_d       = slot_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    iss_addr     = j_q;
    iss_tok.kind = TOK_NONE;
    iss_tok.idx  = INDEX_W'(j_q);
    iss_tok.bad  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.kind)
            CMD_LOAD: begin
              mem_we  = 1'b1;
              q_pop_o = 1'b1;
            end
            CMD_BAD: begin
              if (adv) begin
                iss_tok.kind = TOK_END;
                iss_tok.bad  = 1'b1;
                q_pop_o      = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (adv) begin
                iss_tok.kind = TOK_QPOINT;
                iss_addr     = q_cmd_i.index[AW-1:0];
                slot_d       = q_cmd_i.index[AW-1:0];
                j_d          = '0;
                q_pop_o      = 1'b1;
                state_d      = ST_SCAN;
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (adv) begin
          iss_tok.kind = (j_q == slot_q) ? TOK_NONE : TOK_CAND;
          if (scan_last) begin
            state_d = ST_END;
          end else begin
            j_d = j_q + AW'(1);
          end
        end
      end
      ST_END: begin
        if (adv) begin
          iss_tok.kind = TOK_END;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // point store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[q_cmd_i.index[AW-1:0]] <= {q_cmd_i.x[CW-1:0], q_cmd_i.y[CW-1:0]};
    end
    if (adv) begin
      rd_q <= mem[iss_addr];
    end
  end

  assign rx = rd_q[PW-1:CW];
  assign ry = rd_q[CW-1:0];

  always_comb begin
    dx_d     = (rx >= qx_q) ? rx - qx_q : qx_q - rx;
    dy_d     = (ry >= qy_q) ? ry - qy_q : qy_q - ry;
    sx_d     = PW'(dx_q) * PW'(dx_q);
    sy_d     = PW'(dy_q) * PW'(dy_q);
    dist_sum = SW'(sx_q) + SW'(sy_q);
    hit      = dist_sum <= SW'(r2_q);
  end

  always_ff @(posedge clk_i) begin
    r2_q <= RW'(radius_i) * RW'(radius_i);
    if (adv) begin
      if (tok1_q.kind == TOK_QPOINT) begin
        qx_q <= rx;
        qy_q <= ry;
      end
      dx_q <= dx_d;
      dy_q <= dy_d;
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      slot_q  <= '0;
      tok1_q  <= '{kind: TOK_NONE, idx: '0, bad: 1'b0};
      tok2_q  <= '{kind: TOK_NONE, idx: '0, bad: 1'b0};
      tok3_q  <= '{kind: TOK_NONE, idx: '0, bad: 1'b0};
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      slot_q  <= slot_d;
      if (adv) begin
        tok1_q <= iss_tok;
        tok2_q <= tok1_q;
        tok3_q <= tok2_q;
      end
    end
  end

  // one hit is held back so the last one can carry the last flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b0;
      if (tok3_q.kind == TOK_CAND && hit) begin
        pend_v_q <= 1'b1;
        out_v_q  <= pend_v_q;
      end else if (tok3_q.kind == TOK_END) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (tok3_q.kind == TOK_CAND && hit) begin
        pend_idx_q <= tok3_q.idx;
        out_idx_q  <= pend_idx_q;
        out_nv_q   <= 1'b1;
        out_last_q <= 1'b0;
        out_bad_q  <= 1'b0;
      end else if (tok3_q.kind == TOK_END) begin
        out_last_q <= 1'b1;
        out_bad_q  <= tok3_q.bad;
        if (!tok3_q.bad && pend_v_q) begin
          out_idx_q <= pend_idx_q;
          out_nv_q  <= 1'b1;
        end else begin
          out_idx_q <= '0;
          out_nv_q  <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign neighbor_index_o = out_idx_q;
  assign neighbor_valid_o = out_nv_q;
  assign last_o           = out_last_q;
  assign bad_index_o      = out_bad_q;

endmodule

[hw/rtl/fixed_radius_neighbor_list.sv]
// result order, scan unit idle: a bad query's result passes the read, difference and square
//   registers to the output register; a query's result for one neighbor is held back until the
//   scan reaches k, the next neighbor's slot, or n for the closing result, n = active point count
// scan: a query reads its own point, then one stored point per cycle while the output does not
//   stall, then closes; a bad query or a load needs no scan of the stored points
// reset: clears control state and the queue, point_count 64, radius 320, store untouched
`timescale 1ns / 1ps

module fixed_radius_neighbor_list #(
  parameter int MAX_POINTS = frnl_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = frnl_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [frnl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frnl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [frnl_pkg::INDEX_W-1:0]    point_index_i,
  input  logic [frnl_pkg::COORD_W-1:0]    coord_x_i,
  input  logic [frnl_pkg::COORD_W-1:0]    coord_y_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [frnl_pkg::INDEX_W-1:0]    neighbor_index_o,
  output logic                            neighbor_valid_o,
  output logic                            last_o,
  output logic                            bad_index_o
);
  import frnl_pkg::*;

  localparam int Depth = (MAX_POINTS < INDEX_SPACE) ? MAX_POINTS : INDEX_SPACE;

  logic [CNT_W-1:0]    point_count_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [CNT_W-1:0]    n_eff;

  logic q_push, q_full, q_valid, q_pop;
  cmd_t push_cmd, head_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= POINT_COUNT_RST;
      radius_q      <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT: point_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_RADIUS:      radius_q      <= cfg_wdata_i[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // slots in use, clipped to the table size
  assign n_eff = (point_count_q > CNT_W'(Depth)) ? CNT_W'(Depth) : point_count_q;

  // front: classifies each request as load, query or bad query
  frnl_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .point_index_i (point_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .n_eff_i       (n_eff),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  // short command queue decouples request intake from the scan
  frnl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (q_pop)
  );

  // back: point store, distance pipeline and result register
  frnl_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_cmd_i          (head_cmd),
    .q_pop_o          (q_pop),
    .n_eff_i          (n_eff),
    .radius_i         (radius_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .neighbor_index_o (neighbor_index_o),
    .neighbor_valid_o (neighbor_valid_o),
    .last_o           (last_o),
    .bad_index_o      (bad_index_o)
  );

endmodule
